/* rtl/fmba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmba_pkg
// Shared types, codes and constants for the fit-mode block allocator.
// ----------------------------------------------------------------------------
package fmba_pkg;

  localparam int unsigned HeapBytesDefault   = 65536;
  localparam int unsigned MaxBlocksDefault   = 64;
  localparam int unsigned HeaderBytesDefault = 32;

  localparam int unsigned LenW  = 17;
  localparam int unsigned OffW  = 16;
  localparam int unsigned CfgW  = 17;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [CfgIdxW-1:0] CfgHeapSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFitMode  = 1'b1;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoSpace = 2'd1;
  localparam logic [1:0] StBadPtr  = 2'd2;

  localparam logic [1:0] FitFirst = 2'd0;
  localparam logic [1:0] FitBest  = 2'd1;
  localparam logic [1:0] FitWorst = 2'd2;
  localparam logic [1:0] FitNone  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic scan_step;
    logic shift_step;
    logic write_new;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic early_fail;
    logic scan_last;
    logic scan_hit;
    logic shift_last;
    logic is_free;
  } dp_sts_t;

endpackage
`default_nettype wire

/* rtl/fmba_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmba_req_if / fmba_rsp_if
// Valid/ready channels for request and result words.
// ----------------------------------------------------------------------------
interface fmba_req_if;
  logic                              valid;
  logic                              ready;
  logic                              op;
  logic [fmba_pkg::LenW-1:0]         request_size;
  logic [fmba_pkg::OffW-1:0]         free_offset;
  modport source (output valid, op, request_size, free_offset, input ready);
  modport sink   (input valid, op, request_size, free_offset, output ready);
endinterface

interface fmba_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        status;
  logic [fmba_pkg::OffW-1:0]         block_offset;
  logic [fmba_pkg::LenW-1:0]         granted_size;
  modport source (output valid, status, block_offset, granted_size, input ready);
  modport sink   (input valid, status, block_offset, granted_size, output ready);
endinterface
`default_nettype wire

/* rtl/fmba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmba_ctrl
// Sequencer: accept, scan table, shift entries, write, deliver result.
// ----------------------------------------------------------------------------
module fmba_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire fmba_pkg::dp_sts_t sts_i,
  output fmba_pkg::dp_cmd_t     cmd_o
);

  fmba_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmba_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fmba_pkg::S_IDLE: begin
        if (in_valid_i) state_d = fmba_pkg::S_SCAN;
      end
      fmba_pkg::S_SCAN: begin
        if (sts_i.early_fail) begin
          state_d = fmba_pkg::S_DONE;
        end else if (sts_i.scan_hit || sts_i.scan_last) begin
          if (sts_i.scan_hit) state_d = fmba_pkg::S_SHIFT;
          else state_d = fmba_pkg::S_DONE;
        end
      end
      fmba_pkg::S_SHIFT: begin
        if (sts_i.shift_last) begin
          state_d = sts_i.is_free ? fmba_pkg::S_DONE : fmba_pkg::S_WRITE;
        end
      end
      fmba_pkg::S_WRITE: state_d = fmba_pkg::S_DONE;
      fmba_pkg::S_DONE: begin
        if (out_ready_i) state_d = fmba_pkg::S_IDLE;
      end
      default: state_d = fmba_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      fmba_pkg::S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.start = in_valid_i;
      end
      fmba_pkg::S_SCAN:  cmd_o.scan_step  = !sts_i.early_fail;
      fmba_pkg::S_SHIFT: cmd_o.shift_step = 1'b1;
      fmba_pkg::S_WRITE: cmd_o.write_new  = 1'b1;
      fmba_pkg::S_DONE: begin
        out_valid_o  = 1'b1;
        cmd_o.commit = out_ready_i;
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o) else $error("result dropped");
  a_start_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> state_q == fmba_pkg::S_SCAN) else $error("start lost");
`endif

endmodule
`default_nettype wire

/* rtl/fmba_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fmba_dp
// Block table memory, hole scan, entry shifter and result register.
// ----------------------------------------------------------------------------
module fmba_dp #(
  parameter int unsigned HEAP_BYTES   = fmba_pkg::HeapBytesDefault,
  parameter int unsigned MAX_BLOCKS   = fmba_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = fmba_pkg::HeaderBytesDefault
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [fmba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [fmba_pkg::CfgW-1:0]   cfg_data_i,
  input  wire logic                        op_i,
  input  wire logic [fmba_pkg::LenW-1:0]   request_size_i,
  input  wire logic [fmba_pkg::OffW-1:0]   free_offset_i,
  input  wire fmba_pkg::dp_cmd_t           cmd_i,
  output fmba_pkg::dp_sts_t                sts_o,
  output logic [1:0]                       status_o,
  output logic [fmba_pkg::OffW-1:0]        block_offset_o,
  output logic [fmba_pkg::LenW-1:0]        granted_size_o
);

  localparam int unsigned IdxW = $clog2(MAX_BLOCKS);
  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW   = 19;  // holds start + header + length
  localparam logic [fmba_pkg::LenW-1:0] HeapLimit =
    (HEAP_BYTES < 65536) ? fmba_pkg::LenW'(HEAP_BYTES) : fmba_pkg::LenW'(65536);
  localparam logic [AW-1:0] Hdr = AW'(HEADER_BYTES);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BLOCKS);

  // table, one word holds start and length
  logic [fmba_pkg::OffW+fmba_pkg::LenW-1:0] mem [MAX_BLOCKS];
  logic [fmba_pkg::OffW+fmba_pkg::LenW-1:0] rd_q;

  logic [fmba_pkg::LenW-1:0] heap_q;
  logic [1:0]                fit_q;
  logic [CntW-1:0]           cnt_q;

  logic                      op_q;
  logic [fmba_pkg::LenW-1:0] size_q;
  logic [fmba_pkg::OffW-1:0] foff_q;
  logic [AW-1:0]             need_q;
  logic [CntW-1:0]           i_q;      // scan index
  logic                      rd_ok_q;  // rd_q holds entry i_q
  logic [AW-1:0]             prev_q;
  logic                      found_q;
  logic [AW-1:0]             ppos_q, phole_q;
  logic [CntW-1:0]           pidx_q;
  logic [CntW-1:0]           k_q;      // shift index
  logic [1:0]                st_q;
  logic [fmba_pkg::OffW-1:0] boff_q;
  logic [fmba_pkg::LenW-1:0] gsz_q;

  // scan combinational view
  logic              at_end;
  logic [AW-1:0]     lim, hole, ent_end;
  logic              fits, take, brk, match;
  logic [fmba_pkg::OffW-1:0] ent_start;
  logic [fmba_pkg::LenW-1:0] ent_len;

  assign ent_start = rd_q[fmba_pkg::OffW+fmba_pkg::LenW-1:fmba_pkg::LenW];
  assign ent_len   = rd_q[fmba_pkg::LenW-1:0];
  assign at_end    = (i_q == cnt_q);
  assign lim       = at_end ? AW'(heap_q) : AW'(ent_start);
  assign hole      = (lim > prev_q) ? lim - prev_q : '0;
  assign ent_end   = AW'(ent_start) + Hdr + AW'(ent_len);
  assign fits      = hole >= need_q;
  assign take      = fits && (!found_q || (fit_q == fmba_pkg::FitBest && hole < phole_q)
                     || (fit_q == fmba_pkg::FitWorst && hole > phole_q));
  assign brk       = fits && (fit_q == fmba_pkg::FitFirst ||
                     (fit_q == fmba_pkg::FitBest && hole == need_q));
  assign match     = !at_end && (ent_start == foff_q);

  logic early_alloc, early_free;
  assign early_alloc = (fit_q == fmba_pkg::FitNone) || (need_q > AW'(heap_q)) ||
                       (cnt_q >= CntMax);
  assign early_free  = AW'(foff_q) >= AW'(heap_q);

  // read address: scan reads index i_q, shifts read neighbor
  logic [IdxW-1:0] ra;
  logic            scan_wait;
  assign scan_wait = !rd_ok_q && !at_end;

  logic [CntW-1:0] kp1, km1;
  assign kp1 = k_q + 1'b1;
  assign km1 = k_q - 1'b1;

  always_comb begin
    ra = i_q[IdxW-1:0];
    if (cmd_i.shift_step) begin
      ra = op_q ? kp1[IdxW-1:0] : km1[IdxW-1:0];
    end
  end

  // shift phase: each entry is read, then written, via rd_ok_q toggling
  logic shift_done;
  assign shift_done = op_q ? (kp1 >= cnt_q) : (k_q <= pidx_q);

  always_comb begin
    sts_o.is_free    = op_q;
    sts_o.early_fail = (i_q == '0) && !rd_ok_q && (op_q ? early_free : early_alloc);
    sts_o.scan_hit   = op_q ? (rd_ok_q && match)
                            : (!scan_wait && (at_end || brk) && (take || found_q));
    sts_o.scan_last  = op_q ? (rd_ok_q && at_end) || (at_end && !rd_ok_q && i_q != '0)
                            || (cnt_q == '0)
                            : (!scan_wait && at_end);
    sts_o.shift_last = shift_done || (rd_ok_q && (op_q ? (kp1 + 1'b1 >= cnt_q)
                                                        : (km1 <= pidx_q)));
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[ra];
    if (cmd_i.shift_step && rd_ok_q && !shift_done) begin
      mem[k_q[IdxW-1:0]] <= rd_q;
    end
    if (cmd_i.write_new) begin
      mem[pidx_q[IdxW-1:0]] <= {ppos_q[fmba_pkg::OffW-1:0], gsz_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= HeapLimit;
      fit_q  <= fmba_pkg::FitFirst;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fmba_pkg::CfgHeapSize) begin
          heap_q <= (cfg_data_i > HeapLimit) ? HeapLimit : cfg_data_i;
        end else begin
          fit_q <= cfg_data_i[1:0];
        end
      end
      if (cmd_i.commit && st_q == fmba_pkg::StOk) begin
        cnt_q <= op_q ? cnt_q - 1'b1 : cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q    <= op_i;
      size_q  <= request_size_i;
      foff_q  <= free_offset_i;
      need_q  <= AW'(request_size_i) + Hdr;
      i_q     <= '0;
      rd_ok_q <= 1'b0;
      prev_q  <= '0;
      found_q <= 1'b0;
      st_q    <= op_i ? fmba_pkg::StBadPtr : fmba_pkg::StNoSpace;
      boff_q  <= op_i ? free_offset_i : '0;
      gsz_q   <= '0;
    end else if (cmd_i.scan_step) begin
      if (scan_wait) begin
        rd_ok_q <= 1'b1;
      end else if (op_q) begin
        if (match) begin
          st_q   <= fmba_pkg::StOk;
          gsz_q  <= ent_len;
          k_q    <= i_q;
          rd_ok_q <= 1'b0;
        end else begin
          i_q     <= i_q + 1'b1;
          rd_ok_q <= 1'b0;
        end
      end else begin
        if (take) begin
          found_q <= 1'b1;
          ppos_q  <= prev_q;
          phole_q <= hole;
          pidx_q  <= i_q;
        end
        if ((at_end || brk) && (take || found_q)) begin
          st_q   <= fmba_pkg::StOk;
          k_q    <= cnt_q;
          rd_ok_q <= 1'b0;
          begin : grant
            logic [AW-1:0] ph, pp, lo;
            ph = take ? hole : phole_q;
            pp = take ? prev_q : ppos_q;
            lo = ph - need_q;
            boff_q <= pp[fmba_pkg::OffW-1:0];
            gsz_q  <= (lo < Hdr) ? size_q + lo[fmba_pkg::LenW-1:0] : size_q;
          end
        end else begin
          prev_q  <= ent_end;
          i_q     <= i_q + 1'b1;
          rd_ok_q <= 1'b0;
        end
      end
    end else if (cmd_i.shift_step) begin
      if (!rd_ok_q) begin
        rd_ok_q <= !shift_done;
      end else begin
        rd_ok_q <= 1'b0;
        k_q <= op_q ? kp1 : km1;
      end
    end
  end

  assign status_o       = st_q;
  assign block_offset_o = boff_q;
  assign granted_size_o = gsz_q;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax) else $error("block count overflow");
  a_heap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_q <= HeapLimit) else $error("heap size above limit");
  a_commit_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && st_q != fmba_pkg::StOk) |=> $stable(cnt_q))
    else $error("count changed on failure");
`endif

endmodule
`default_nettype wire

/* rtl/fit_mode_block_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fit_mode_block_allocator
// Heap block allocator with first, best and worst fit placement.
// ----------------------------------------------------------------------------
// One request is handled at a time. The scan walks the address-ordered block
// table, reading each entry into a register before it is checked; inserting or
// removing a block then moves the entries above it, each read and then written.
// The result word is held until taken.
module fit_mode_block_allocator #(
  parameter int unsigned HEAP_BYTES   = fmba_pkg::HeapBytesDefault,
  parameter int unsigned MAX_BLOCKS   = fmba_pkg::MaxBlocksDefault,
  parameter int unsigned HEADER_BYTES = fmba_pkg::HeaderBytesDefault
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [fmba_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [fmba_pkg::CfgW-1:0]    cfg_data_i,
  fmba_req_if.sink                          req,
  fmba_rsp_if.source                        rsp
);

  fmba_pkg::dp_cmd_t cmd;
  fmba_pkg::dp_sts_t sts;

  fmba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .out_valid_o (rsp.valid),
    .out_ready_i (rsp.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fmba_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (req.op),
    .request_size_i (req.request_size),
    .free_offset_i  (req.free_offset),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (rsp.status),
    .block_offset_o (rsp.block_offset),
    .granted_size_o (rsp.granted_size)
  );

endmodule
`default_nettype wire
